>>> rtl/core/ttn_pkg.sv
// shared types, constants and character class functions of the text token normalizer
package ttn_pkg;

   localparam int TOKEN_CHARS_DEF = 32;
   localparam int TOKEN_CHARS_MAX = 64;
   localparam int CNT_MAX_W       = $clog2(TOKEN_CHARS_MAX + 1);
   localparam int WEB_LEN         = 5;

   localparam logic [7:0] CHAR_SPACE   = 8'd32;
   localparam logic [7:0] CHAR_NEWLINE = 8'd10;

   // one emit request: the held token that the back end streams out
   typedef struct packed {
      logic                 buf_sel;
      logic [CNT_MAX_W-1:0] count;
      logic                 cut;
   } emit_cmd_type;

   // back end progress, used by the front end to avoid overwriting unread data
   typedef struct packed {
      logic                 active;
      logic                 buf_sel;
      logic [CNT_MAX_W-1:0] rd_ptr;
   } back_stat_type;

   // queue occupancy as seen by the front end
   typedef struct packed {
      logic       full;
      logic [1:0] buf_busy;
   } queue_stat_type;

   function automatic logic in_trail(input logic [7:0] c);
      logic hit;
      unique case (c) inside
         "?", ".", ",", ";", "\"", "'", "(", ")", "[", "]", "_", "!",
         "-", ":", "=", "|", "&", "#", "/", "<", ">", "*", CHAR_NEWLINE: hit = 1'b1;
         default: hit = 1'b0;
      endcase
      return hit;
   endfunction

   function automatic logic in_lead(input logic [7:0] c);
      return (c == "@") || ((c != CHAR_NEWLINE) && in_trail(c));
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return ((c >= "A") && (c <= "Z")) ? (c | 8'h20) : c;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   // characters of the web prefix that marks a dropped token
   function automatic logic [7:0] web_char(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = "h";
         3'd1:    ch = "t";
         3'd2:    ch = "t";
         3'd3:    ch = "p";
         default: ch = ":";
      endcase
      return ch;
   endfunction

endpackage

>>> rtl/core/ttn_ram.sv
// generic single write port ram with registered read
module ttn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/ttn_front.sv
// front end: takes text words, strips, lowercases, stores tokens and issues emit requests
module ttn_front #(
   parameter int TOKEN_CHARS = ttn_pkg::TOKEN_CHARS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_text_byte,
   output logic                               wr_en,
   output logic [$clog2(2*TOKEN_CHARS)-1:0]   wr_addr,
   output logic [7:0]                         wr_data,
   output logic                               push_valid,
   output ttn_pkg::emit_cmd_type              push_cmd,
   input  ttn_pkg::queue_stat_type            q_stat,
   input  ttn_pkg::back_stat_type             b_stat
);
   import ttn_pkg::*;

   localparam int CW = $clog2(TOKEN_CHARS + 1);
   localparam int AW = $clog2(2 * TOKEN_CHARS);

   logic [CW-1:0] fill_cnt_ff, fill_cnt_in;
   logic [CW-1:0] keep_ff, keep_in;
   logic          body_ff, body_in;
   logic          digits_ff, digits_in;
   logic          ovf_ff, ovf_in;
   logic          match_ff, match_in;
   logic          held_valid_ff, held_valid_in;
   logic [CW-1:0] held_count_ff, held_count_in;
   logic          held_cut_ff, held_cut_in;
   logic          sel_ff, sel_in;

   logic [7:0] lc;
   logic       is_sep;
   logic       lead_skip;
   logic       store;
   logic       hazard;
   logic       kept;
   logic       need_push;
   logic       accept;

   assign lc        = to_lower(req_text_byte);
   assign is_sep    = (req_text_byte == CHAR_SPACE) || (req_text_byte == CHAR_NEWLINE);
   assign lead_skip = !body_ff && in_lead(req_text_byte);
   assign store     = !is_sep && !lead_skip && (fill_cnt_ff < CW'(TOKEN_CHARS));

   // the slot about to be written may still be waiting for the back end
   assign hazard = q_stat.buf_busy[sel_ff] ||
                   (b_stat.active && (b_stat.buf_sel == sel_ff) &&
                    (b_stat.rd_ptr <= CNT_MAX_W'(fill_cnt_ff)));

   assign kept = (keep_ff != '0) && !((keep_ff > CW'(WEB_LEN)) && match_ff) && !digits_ff;
   assign need_push = is_sep && kept && held_valid_ff;

   assign req_ready = !(store && hazard) && !(need_push && q_stat.full);
   assign accept    = req_valid && req_ready;

   assign wr_addr = AW'(fill_cnt_ff) + (sel_ff ? AW'(TOKEN_CHARS) : AW'(0));
   assign wr_data = lc;

   assign push_cmd.buf_sel = ~sel_ff;
   assign push_cmd.count   = CNT_MAX_W'(held_count_ff);
   assign push_cmd.cut     = held_cut_ff;

   always_comb begin
      fill_cnt_in   = fill_cnt_ff;
      keep_in       = keep_ff;
      body_in       = body_ff;
      digits_in     = digits_ff;
      ovf_in        = ovf_ff;
      match_in      = match_ff;
      held_valid_in = held_valid_ff;
      held_count_in = held_count_ff;
      held_cut_in   = held_cut_ff;
      sel_in        = sel_ff;
      wr_en         = 1'b0;
      push_valid    = 1'b0;
      if (accept) begin
         if (!is_sep) begin
            if (!lead_skip) begin
               body_in = 1'b1;
               if (!store) begin
                  ovf_in = 1'b1;
               end else begin
                  wr_en = 1'b1;
                  if (fill_cnt_ff < CW'(WEB_LEN)) begin
                     match_in = match_ff && (lc == web_char(fill_cnt_ff[2:0]));
                  end
                  if (!in_trail(lc)) begin
                     if ((fill_cnt_ff != keep_ff) || !is_digit(lc)) begin
                        digits_in = 1'b0;
                     end
                     keep_in = fill_cnt_ff + CW'(1);
                  end
                  fill_cnt_in = fill_cnt_ff + CW'(1);
               end
            end
         end else begin
            if (kept) begin
               push_valid    = held_valid_ff;
               held_valid_in = 1'b1;
               held_count_in = keep_ff;
               held_cut_in   = ovf_ff;
               sel_in        = ~sel_ff;
            end
            fill_cnt_in = '0;
            keep_in     = '0;
            body_in     = 1'b0;
            digits_in   = 1'b1;
            ovf_in      = 1'b0;
            match_in    = 1'b1;
            if (req_text_byte == CHAR_NEWLINE) begin
               held_valid_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_cnt_ff   <= '0;
         keep_ff       <= '0;
         body_ff       <= 1'b0;
         digits_ff     <= 1'b1;
         ovf_ff        <= 1'b0;
         match_ff      <= 1'b1;
         held_valid_ff <= 1'b0;
         held_count_ff <= '0;
         held_cut_ff   <= 1'b0;
         sel_ff        <= 1'b0;
      end else begin
         fill_cnt_ff   <= fill_cnt_in;
         keep_ff       <= keep_in;
         body_ff       <= body_in;
         digits_ff     <= digits_in;
         ovf_ff        <= ovf_in;
         match_ff      <= match_in;
         held_valid_ff <= held_valid_in;
         held_count_ff <= held_count_in;
         held_cut_ff   <= held_cut_in;
         sel_ff        <= sel_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !(b_stat.active && (b_stat.buf_sel == sel_ff) &&
                  (b_stat.rd_ptr <= CNT_MAX_W'(fill_cnt_ff))))
      else $error("token slot written before the back end read it");
   a_keep_le_fill: assert property (@(posedge clock) disable iff (reset)
      keep_ff <= fill_cnt_ff)
      else $error("kept length beyond stored length");
`endif

endmodule

>>> rtl/core/ttn_cmd_q.sv
// two entry queue of emit requests between front and back end
module ttn_cmd_q (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_valid,
   input  ttn_pkg::emit_cmd_type   push_cmd,
   input  logic                    pop,
   output logic                    head_valid,
   output ttn_pkg::emit_cmd_type   head_cmd,
   output ttn_pkg::queue_stat_type stat
);
   import ttn_pkg::*;

   emit_cmd_type ent_ff [2];
   logic         wp_ff, wp_in;
   logic         rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic [1:0]   ent_valid;

   assign head_valid = (cnt_ff != 2'd0);
   assign head_cmd   = ent_ff[rp_ff];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         ent_valid[i] = (cnt_ff == 2'd2) || ((cnt_ff == 2'd1) && (rp_ff == 1'(i)));
      end
      stat.full        = (cnt_ff == 2'd2);
      stat.buf_busy[0] = (ent_valid[0] && !ent_ff[0].buf_sel) ||
                         (ent_valid[1] && !ent_ff[1].buf_sel);
      stat.buf_busy[1] = (ent_valid[0] && ent_ff[0].buf_sel) ||
                         (ent_valid[1] && ent_ff[1].buf_sel);
   end

   always_comb begin
      wp_in  = push_valid ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(push_valid) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         ent_ff[wp_ff] <= push_cmd;
      end
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !stat.full)
      else $error("emit request pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("emit request popped from an empty queue");
   a_nonempty_cmd: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (push_cmd.count != '0))
      else $error("emit request for an empty token");
`endif

endmodule

>>> rtl/core/ttn_back.sv
// back end: streams a held token out of the store, one character per word
module ttn_back #(
   parameter int TOKEN_CHARS = ttn_pkg::TOKEN_CHARS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  ttn_pkg::emit_cmd_type            head_cmd,
   output logic                             pop,
   output logic                             rd_en,
   output logic [$clog2(2*TOKEN_CHARS)-1:0] rd_addr,
   input  logic [7:0]                       rd_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_token_char,
   output logic                             rsp_token_end,
   output logic                             rsp_token_cut,
   output ttn_pkg::back_stat_type           stat
);
   import ttn_pkg::*;

   localparam int CW = $clog2(TOKEN_CHARS + 1);
   localparam int AW = $clog2(2 * TOKEN_CHARS);

   logic          active_ff, active_in;
   logic          sel_ff, sel_in;
   logic [CW-1:0] count_ff, count_in;
   logic          cut_ff, cut_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic          infl_ff, infl_in;
   logic          infl_last_ff, infl_last_in;
   logic          infl_cut_ff, infl_cut_in;
   logic          out_valid_ff, out_valid_in;
   logic [7:0]    out_char_ff;
   logic          out_end_ff;
   logic          out_cut_ff;

   logic          issue;
   logic          last;

   assign pop   = head_valid && !active_ff;
   assign issue = active_ff && !infl_ff && (!out_valid_ff || rsp_ready);
   assign last  = (CW'(ptr_ff + CW'(1)) == count_ff);
   assign rd_en = issue;
   assign rd_addr = AW'(ptr_ff) + (sel_ff ? AW'(TOKEN_CHARS) : AW'(0));

   assign stat.active  = active_ff;
   assign stat.buf_sel = sel_ff;
   assign stat.rd_ptr  = CNT_MAX_W'(ptr_ff);

   assign rsp_valid      = out_valid_ff;
   assign rsp_token_char = out_char_ff;
   assign rsp_token_end  = out_end_ff;
   assign rsp_token_cut  = out_cut_ff;

   always_comb begin
      active_in    = active_ff;
      sel_in       = sel_ff;
      count_in     = count_ff;
      cut_in       = cut_ff;
      ptr_in       = ptr_ff;
      infl_in      = issue;
      infl_last_in = infl_last_ff;
      infl_cut_in  = infl_cut_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (infl_ff) begin
         out_valid_in = 1'b1;
      end
      if (pop) begin
         active_in = 1'b1;
         sel_in    = head_cmd.buf_sel;
         count_in  = head_cmd.count[CW-1:0];
         cut_in    = head_cmd.cut;
         ptr_in    = '0;
      end
      if (issue) begin
         ptr_in       = ptr_ff + CW'(1);
         infl_last_in = last;
         infl_cut_in  = cut_ff;
         if (last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (infl_ff) begin
         out_char_ff <= rd_data;
         out_end_ff  <= infl_last_ff;
         out_cut_ff  <= infl_cut_ff;
      end
      sel_ff       <= sel_in;
      count_ff     <= count_in;
      cut_ff       <= cut_in;
      infl_last_ff <= infl_last_in;
      infl_cut_ff  <= infl_cut_in;
      if (reset) begin
         active_ff    <= 1'b0;
         ptr_ff       <= '0;
         infl_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         ptr_ff       <= ptr_in;
         infl_ff      <= infl_in;
         out_valid_ff <= out_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_load_into_empty: assert property (@(posedge clock) disable iff (reset)
      infl_ff |-> !out_valid_ff)
      else $error("read data arrives while the output word is still held");
   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      active_ff |-> (ptr_ff < count_ff))
      else $error("read pointer past token length");
`endif

endmodule

>>> rtl/core/text_token_normalizer_unit.sv
// top level of the text token normalizer: front end, emit queue, back end and token store
//
// Text arrives one byte per req_ word; byte 32 separates tokens and byte 10 ends a line.
// Each token is lowercased (A-Z only), stripped of leading punctuation (including '@')
// and trailing punctuation (including newline), and dropped if it comes out empty, is
// all digits, or is longer than five characters and starts with "http:". Within a line
// every kept token is held back until the next kept token arrives, so the last kept
// token of each line never comes out. An emitted token appears as one rsp_ word per
// character, with rsp_token_end on its last character and rsp_token_cut on every
// character of a token that ran past TOKEN_CHARS stored characters (the excess is
// dropped). The front end takes one byte per cycle; it holds off only when the next
// character would land in a store slot the back end has not read yet, or when a token
// completes while both emit queue entries are taken. The back end reads each character
// through the registered store read into the output register; it starts the next read
// only after the last one has landed there. The token store is two buffers of TOKEN_CHARS
// bytes in one ram; it needs no clearing after reset.
module text_token_normalizer_unit #(
   parameter int TOKEN_CHARS = ttn_pkg::TOKEN_CHARS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_token_char,
   output logic       rsp_token_end,
   output logic       rsp_token_cut
);
   import ttn_pkg::*;

   localparam int AW = $clog2(2 * TOKEN_CHARS);

   // store write side, driven by the front end
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;

   // store read side, driven by the back end
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data;

   // emit request path
   logic           push_valid;
   emit_cmd_type   push_cmd;
   logic           pop;
   logic           head_valid;
   emit_cmd_type   head_cmd;
   queue_stat_type q_stat;
   back_stat_type  b_stat;

   // classify, strip and store characters, decide which tokens survive
   ttn_front #(
      .TOKEN_CHARS(TOKEN_CHARS)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .push_valid    (push_valid),
      .push_cmd      (push_cmd),
      .q_stat        (q_stat),
      .b_stat        (b_stat)
   );

   // decouples token completion from character output
   ttn_cmd_q u_cmd_q (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .stat       (q_stat)
   );

   // two token buffers side by side
   ttn_ram #(
      .WIDTH (8),
      .DEPTH (2 * TOKEN_CHARS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // streams held tokens out through the output register
   ttn_back #(
      .TOKEN_CHARS(TOKEN_CHARS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_cmd       (head_cmd),
      .pop            (pop),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_token_char (rsp_token_char),
      .rsp_token_end  (rsp_token_end),
      .rsp_token_cut  (rsp_token_cut),
      .stat           (b_stat)
   );

`ifndef SYNTHESIS
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("store slot written and read in the same cycle");
   a_pop_when_idle: assert property (@(posedge clock) disable iff (reset)
      pop |-> !b_stat.active)
      else $error("emit request taken while a token is still streaming");
`endif

endmodule
